FILE: sv/tcg_pkg.sv
// Texture coordinate generator package: fixed-point format, register and mode codes,
// pipeline stage types and the saturation helper.
// No dependencies.
package tcg_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [31:0] ONE_Q  = 32'(1) << FRAC_BITS;
  localparam logic [31:0] HALF_Q = 32'(1) << (FRAC_BITS - 1);
  localparam logic signed [67:0] ONE_W  = 68'sd1 <<< FRAC_BITS;
  localparam logic signed [67:0] HALF_W = 68'sd1 <<< (FRAC_BITS - 1);

  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_OBJ    = 3'd1;
  localparam logic [2:0] MODE_EYE    = 3'd2;
  localparam logic [2:0] MODE_SPHERE = 3'd3;
  localparam logic [2:0] MODE_REFL   = 3'd4;
  localparam logic [2:0] MODE_NORMAL = 3'd5;

  localparam logic [1:0] CRD_S = 2'd0;
  localparam logic [1:0] CRD_T = 2'd1;
  localparam logic [1:0] CRD_R = 2'd2;
  localparam logic [1:0] CRD_Q = 2'd3;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_COORD   = 3'd1;
  localparam logic [2:0] REG_PLANE_A = 3'd2;
  localparam logic [2:0] REG_PLANE_B = 3'd3;
  localparam logic [2:0] REG_PLANE_C = 3'd4;
  localparam logic [2:0] REG_PLANE_D = 3'd5;

  localparam int SQ_PER  = 2;
  localparam int SQ_STG  = 32 / SQ_PER;
  localparam int REM_W   = 35;
  localparam int DIV_PER = 2;
  localparam int DIV_STG = (FRAC_BITS + DIV_PER - 1) / DIV_PER;
  localparam int NUM_W   = 33 + FRAC_BITS;

  localparam int PIPE_DEPTH = 5 + 1 + SQ_STG + 1 + DIV_STG + 1;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 2);

  typedef struct packed {
    logic        vld;
    logic        sph;
    logic        neg;
    logic [31:0] early;
    logic [31:0] mag;
  } side_t;

  typedef struct packed {
    side_t            sd;
    logic [REM_W-1:0] rem;
    logic [31:0]      root;
    logic [63:0]      xs;
  } sq_t;

  typedef struct packed {
    side_t                sd;
    logic                 zero;
    logic [NUM_W-1:0]     rem;
    logic [32:0]          den;
    logic [FRAC_BITS-1:0] quo;
  } dv_t;

  function automatic logic [31:0] sat32(input logic signed [67:0] v);
    logic [31:0] res;
    if (v > 68'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -68'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/texture_coordinate_generator.sv
// Texture coordinate generator top level: one generated coordinate per vertex beat.
// Depends on tcg_pkg.
//
// Usage: the in_ channel takes one vertex beat (position xyzw and eye normal xyz,
// all signed Q16.16); the out_ channel returns one signed Q16.16 texcoord per beat,
// in order. The cfg_ channel writes mode, coordinate select and plane a..d by index;
// write it only while no beat is in flight. cfg_ready is always high.
// Stages: 5 front stages, 1 sum stage, 16 square-root stages at two root bits each,
// 1 divider setup stage, 8 divider stages at two quotient bits each, 1 output
// register. The root and divider stages set the depth; every stage takes a new
// beat each cycle while the pipeline is not stalled.
// Throughput: one beat per cycle while out_ready is high.
// Stall: when the output register holds a beat that is not taken, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and the configuration
// registers (mode none, coordinate s, planes zero).
module texture_coordinate_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic signed [31:0] in_vertex_z,
  input  logic signed [31:0] in_vertex_w,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_texcoord,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tcg_pkg::*;

  logic [2:0]         mode_r;
  logic [1:0]         coord_r;
  logic signed [31:0] plane_r [4];

  logic en;
  logic lin;

  logic               vld1_r;
  logic signed [31:0] v1_r [3];
  logic signed [31:0] n1_r [3];
  logic signed [63:0] prod1_r [4];
  logic signed [31:0] opa [4];
  logic signed [31:0] opb [4];

  logic               vld2_r;
  logic signed [31:0] v2_r [3];
  logic signed [31:0] n2_r [3];
  logic [31:0]        lin2_r;
  logic signed [31:0] fdot2_r;
  logic signed [67:0] sum2;
  logic signed [67:0] dot2;

  logic               vld3_r;
  logic signed [31:0] v3_r [3];
  logic signed [31:0] n3_r [3];
  logic [31:0]        lin3_r;
  logic signed [63:0] p3_r [3];

  logic               vld4_r;
  logic signed [31:0] rs4_r [3];
  logic [31:0]        early4_r;
  logic               sph4_r;
  logic signed [31:0] refl [3];
  logic signed [31:0] rsph [3];
  logic [31:0]        early_nxt;
  logic               sph_nxt;
  logic signed [31:0] refl_c;
  logic signed [31:0] norm_c;

  logic [63:0] sq5_r [3];
  logic [31:0] abs4 [3];
  side_t       sd5_r;

  sq_t sq_r [SQ_STG+1];
  dv_t dv_r [DIV_STG+1];

  logic        out_valid_r;
  logic [31:0] out_r;
  logic [31:0] res_nxt;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_texcoord = out_r;
  assign lin = (mode_r == MODE_OBJ) || (mode_r == MODE_EYE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      coord_r <= CRD_S;
      for (int i = 0; i < 4; i++) plane_r[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:    mode_r     <= cfg_data[2:0];
        REG_COORD:   coord_r    <= cfg_data[1:0];
        REG_PLANE_A: plane_r[0] <= cfg_data;
        REG_PLANE_B: plane_r[1] <= cfg_data;
        REG_PLANE_C: plane_r[2] <= cfg_data;
        REG_PLANE_D: plane_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: products for the plane dot or the normal dot
  always_comb begin
    opa[0] = lin ? in_vertex_x : in_normal_x;
    opa[1] = lin ? in_vertex_y : in_normal_y;
    opa[2] = lin ? in_vertex_z : in_normal_z;
    opa[3] = lin ? in_vertex_w : 32'sd0;
    opb[0] = lin ? plane_r[0] : in_vertex_x;
    opb[1] = lin ? plane_r[1] : in_vertex_y;
    opb[2] = lin ? plane_r[2] : in_vertex_z;
    opb[3] = plane_r[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r[0] <= in_vertex_x;
      v1_r[1] <= in_vertex_y;
      v1_r[2] <= in_vertex_z;
      n1_r[0] <= in_normal_x;
      n1_r[1] <= in_normal_y;
      n1_r[2] <= in_normal_z;
      for (int i = 0; i < 4; i++) prod1_r[i] <= opa[i] * opb[i];
    end
    if (!rst_n) vld1_r <= 1'b0;
    else if (en) vld1_r <= in_valid;
  end

  // stage 2: round the dot product and form its saturated double
  always_comb begin
    sum2 = 68'(prod1_r[0]) + 68'(prod1_r[1]) + 68'(prod1_r[2]) + 68'(prod1_r[3]) + HALF_W;
    dot2 = sum2 >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r    <= v1_r;
      n2_r    <= n1_r;
      lin2_r  <= sat32(dot2);
      fdot2_r <= sat32(dot2 <<< 1);
    end
    if (!rst_n) vld2_r <= 1'b0;
    else if (en) vld2_r <= vld1_r;
  end

  // stage 3: n_i * 2(n.v)
  always_ff @(posedge clk) begin
    if (en) begin
      v3_r   <= v2_r;
      n3_r   <= n2_r;
      lin3_r <= lin2_r;
      for (int i = 0; i < 3; i++) p3_r[i] <= n2_r[i] * fdot2_r;
    end
    if (!rst_n) vld3_r <= 1'b0;
    else if (en) vld3_r <= vld2_r;
  end

  // stage 4: reflection vector and every result that skips the sphere path
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      refl[i] = sat32(68'(v3_r[i]) - ((68'(p3_r[i]) + HALF_W) >>> FRAC_BITS));
    end
    rsph[0] = refl[0];
    rsph[1] = refl[1];
    rsph[2] = sat32(68'(refl[2]) + ONE_W);
    case (coord_r)
      CRD_S:   begin refl_c = refl[0]; norm_c = n3_r[0]; end
      CRD_T:   begin refl_c = refl[1]; norm_c = n3_r[1]; end
      CRD_R:   begin refl_c = refl[2]; norm_c = n3_r[2]; end
      default: begin refl_c = '0;      norm_c = '0;      end
    endcase
    sph_nxt = 1'b0;
    case (mode_r) inside
      MODE_OBJ, MODE_EYE: early_nxt = lin3_r;
      MODE_REFL:          early_nxt = (coord_r == CRD_Q) ? ONE_Q : refl_c;
      MODE_NORMAL:        early_nxt = (coord_r == CRD_Q) ? ONE_Q : norm_c;
      MODE_SPHERE: begin
        early_nxt = (coord_r == CRD_Q) ? ONE_Q : '0;
        sph_nxt   = (coord_r == CRD_S) || (coord_r == CRD_T);
      end
      default:            early_nxt = (coord_r == CRD_Q) ? ONE_Q : '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs4_r    <= rsph;
      early4_r <= early_nxt;
      sph4_r   <= sph_nxt;
    end
    if (!rst_n) vld4_r <= 1'b0;
    else if (en) vld4_r <= vld3_r;
  end

  // stage 5: squares of the sphere vector
  always_comb begin
    for (int i = 0; i < 3; i++) abs4[i] = rs4_r[i][31] ? (~rs4_r[i] + 32'd1) : rs4_r[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq5_r[i] <= abs4[i] * abs4[i];
      sd5_r.sph   <= sph4_r;
      sd5_r.early <= early4_r;
      sd5_r.mag   <= abs4[coord_r[0]];
      sd5_r.neg   <= rs4_r[coord_r[0]][31];
    end
    if (!rst_n) sd5_r.vld <= 1'b0;
    else if (en) sd5_r.vld <= vld4_r;
  end

  // stage 6: sum of squares, seed the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r[0].sd.vld <= 1'b0;
    end else if (en) begin
      sq_r[0].sd   <= sd5_r;
      sq_r[0].rem  <= '0;
      sq_r[0].root <= '0;
      sq_r[0].xs   <= sq5_r[0] + sq5_r[1] + sq5_r[2];
    end
  end

  for (genvar k = 0; k < SQ_STG; k++) begin : g_sq
    sq_t sq_nxt;
    always_comb begin
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      sq_nxt = sq_r[k];
      for (int j = 0; j < SQ_PER; j++) begin
        rem2  = {sq_nxt.rem[REM_W-3:0], sq_nxt.xs[63:62]};
        trial = REM_W'({sq_nxt.root, 2'b01});
        if (rem2 >= trial) begin
          sq_nxt.rem  = rem2 - trial;
          sq_nxt.root = {sq_nxt.root[30:0], 1'b1};
        end else begin
          sq_nxt.rem  = rem2;
          sq_nxt.root = {sq_nxt.root[30:0], 1'b0};
        end
        sq_nxt.xs = sq_nxt.xs << 2;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_r[k+1].sd.vld <= 1'b0;
      else if (en) sq_r[k+1] <= sq_nxt;
    end
  end

  // divider setup: (mag * 2^F + m) / (2m)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].sd.vld <= 1'b0;
    end else if (en) begin
      dv_r[0].sd   <= sq_r[SQ_STG].sd;
      dv_r[0].zero <= (sq_r[SQ_STG].root == '0);
      dv_r[0].rem  <= (NUM_W'(sq_r[SQ_STG].sd.mag) << FRAC_BITS) + NUM_W'(sq_r[SQ_STG].root);
      dv_r[0].den  <= {sq_r[SQ_STG].root, 1'b0};
      dv_r[0].quo  <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STG; k++) begin : g_dv
    dv_t dv_nxt;
    always_comb begin
      logic [NUM_W-1:0] cand;
      int               b;
      dv_nxt = dv_r[k];
      for (int j = 0; j < DIV_PER; j++) begin
        b = FRAC_BITS - 1 - (k * DIV_PER + j);
        cand = NUM_W'(dv_nxt.den) << ((b >= 0) ? b : 0);
        if (b >= 0) begin
          if (dv_nxt.rem >= cand) begin
            dv_nxt.rem = dv_nxt.rem - cand;
            dv_nxt.quo = {dv_nxt.quo[FRAC_BITS-2:0], 1'b1};
          end else begin
            dv_nxt.quo = {dv_nxt.quo[FRAC_BITS-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1].sd.vld <= 1'b0;
      else if (en) dv_r[k+1] <= dv_nxt;
    end
  end

  // output register
  always_comb begin
    if (!dv_r[DIV_STG].sd.sph) begin
      res_nxt = dv_r[DIV_STG].sd.early;
    end else if (dv_r[DIV_STG].zero) begin
      res_nxt = HALF_Q;
    end else if (dv_r[DIV_STG].sd.neg) begin
      res_nxt = HALF_Q - 32'(dv_r[DIV_STG].quo);
    end else begin
      res_nxt = HALF_Q + 32'(dv_r[DIV_STG].quo);
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= res_nxt;
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_r[DIV_STG].sd.vld;
  end

endmodule

FILE: sv/tcg_checker.sv
// Port-level checker for the texture coordinate generator, bound to the top level.
// Depends on tcg_pkg and texture_coordinate_generator.
module tcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_texcoord
);
  import tcg_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_texcoord))
    else $error("output beat changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("output beat without an input beat in flight");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind texture_coordinate_generator tcg_checker u_tcg_checker (.*);

FILE: sim/texture_coordinate_generator_tb.sv
// Testbench for texture_coordinate_generator: directed table then random vertex beats,
// every result checked against its row's fixed value or a bit-accurate texgen predictor.
// Depends on tcg_pkg and the texture_coordinate_generator RTL.
`timescale 1ns / 1ps

module texture_coordinate_generator_tb;
  import tcg_pkg::*;

  localparam int LATENCY  = 32;
  localparam int WDOG_MAX = 20000;
  localparam logic [31:0] IMAX = 32'h7fff_ffff;
  localparam logic [31:0] IMIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] vx, vy, vz, vw, nx, ny, nz;
  } vert_t;

  typedef struct {
    logic [2:0]  mode;
    logic [1:0]  crd;
    logic [31:0] pa, pb, pc, pd;
    vert_t       v;
    bit          known;
    logic [31:0] tc;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_vertex_x = '0, in_vertex_y = '0, in_vertex_z = '0, in_vertex_w = '0;
  logic signed [31:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_texcoord;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [2:0]  m_mode;
  logic [1:0]  m_coord;
  logic [31:0] m_plane [4];

  logic [31:0] texcoord_q [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int wdog = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  texture_coordinate_generator dut (.*);

  function automatic logic signed [67:0] sat_w(input logic signed [67:0] x);
    if (x > 68'sd2147483647) return 68'sd2147483647;
    if (x < -68'sd2147483648) return -68'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] s);
    return (s + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] texgen(input vert_t v);
    logic signed [67:0] p[4], nn[3], pl[4], r[3], acc, fdot, res;
    logic [67:0] s, m, q, mag, rb, bt;
    int c;
    c = m_coord;
    p[0] = $signed(v.vx); p[1] = $signed(v.vy); p[2] = $signed(v.vz); p[3] = $signed(v.vw);
    nn[0] = $signed(v.nx); nn[1] = $signed(v.ny); nn[2] = $signed(v.nz);
    for (int i = 0; i < 4; i++) pl[i] = $signed(m_plane[i]);
    res = 0;
    case (m_mode) inside
      MODE_OBJ, MODE_EYE: begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += p[i] * pl[i];
        res = sat_w(rnd_shift(acc));
      end
      MODE_SPHERE, MODE_REFL: begin
        if (c == 3) res = ONE_W;
        else if (m_mode == MODE_SPHERE && c == 2) res = 0;
        else begin
          acc = 0;
          for (int i = 0; i < 3; i++) acc += nn[i] * p[i];
          fdot = sat_w(2 * rnd_shift(acc));
          for (int i = 0; i < 3; i++) r[i] = sat_w(p[i] - rnd_shift(nn[i] * fdot));
          if (m_mode == MODE_REFL) res = r[c];
          else begin
            r[2] = sat_w(r[2] + ONE_W);
            s = 0;
            for (int i = 0; i < 3; i++) s += r[i] * r[i];
            rb = 0;
            bt = 68'd1 << 66;
            while (bt > s) bt >>= 2;
            while (bt != 0) begin
              if (s >= rb + bt) begin
                s -= rb + bt;
                rb = (rb >> 1) + bt;
              end else rb >>= 1;
              bt >>= 2;
            end
            m = rb;
            if (m == 0) res = HALF_W;
            else begin
              mag = r[c] < 0 ? -r[c] : r[c];
              q = ((mag << FRAC_BITS) + m) / (2 * m);
              res = r[c] < 0 ? HALF_W - $signed(q) : HALF_W + $signed(q);
              res = sat_w(res);
            end
          end
        end
      end
      MODE_NORMAL: res = c == 3 ? ONE_W : nn[c];
      default: res = c == 3 ? ONE_W : 0;
    endcase
    return res[31:0];
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:  m_mode = val[2:0];
      REG_COORD: m_coord = val[1:0];
      default:   m_plane[idx - REG_PLANE_A] = val;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (texcoord_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [2:0] mode, input logic [1:0] crd,
                         input logic [31:0] a, b, c, d);
    drain();
    write_reg(REG_MODE, {29'd0, mode});
    write_reg(REG_COORD, {30'd0, crd});
    write_reg(REG_PLANE_A, a);
    write_reg(REG_PLANE_B, b);
    write_reg(REG_PLANE_C, c);
    write_reg(REG_PLANE_D, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(input vert_t v, input bit known, input logic [31:0] tc);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_vertex_x, in_vertex_y, in_vertex_z, in_vertex_w,
     in_normal_x, in_normal_y, in_normal_z} <= v;
    texcoord_q.push_back(known ? tc : texgen(v));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rfield(input int sel);
    case (sel)
      0: return $urandom();
      1: return $urandom_range(1) ? IMAX : IMIN;
      2: return $urandom_range(131072) - 65536;
      default: return {{12{$urandom_range(1) ? 1'b1 : 1'b0}}, 20'($urandom())};
    endcase
  endfunction

  function automatic vert_t rvert(input bit unit);
    vert_t v;
    int sel;
    sel = $urandom_range(3);
    v = {rfield(sel), rfield(sel), rfield(sel), rfield(sel),
         rfield(sel), rfield(sel), rfield(sel)};
    if (unit && $urandom_range(3) != 0) begin
      v.nx = $urandom_range(131072) - 65536;
      v.ny = $urandom_range(131072) - 65536;
      v.nz = $urandom_range(131072) - 65536;
      v.vx = $urandom_range(131072) - 65536;
      v.vy = $urandom_range(131072) - 65536;
      v.vz = $urandom_range(131072) - 65536;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (texcoord_q.size() == 0) begin
          $error("texcoord: unexpected beat, actual %h", out_texcoord);
          errors++;
        end else begin
          if (out_texcoord !== texcoord_q[0]) begin
            $error("texcoord: expected %h actual %h", texcoord_q[0], out_texcoord);
            errors++;
          end
          void'(texcoord_q.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        wdog <= 0;
      else if (wdog + 1 >= WDOG_MAX) begin
        $display("== FAIL ==");
        $finish;
      end else
        wdog <= wdog + 1;
    end
  end

  row_t dir [$];

  task automatic add_row(input logic [2:0] mode, input logic [1:0] crd,
                         input logic [31:0] a, b, c, d,
                         input vert_t v, input bit known, input logic [31:0] tc);
    row_t r;
    r.mode = mode; r.crd = crd;
    r.pa = a; r.pb = b; r.pc = c; r.pd = d;
    r.v = v; r.known = known; r.tc = tc;
    dir.push_back(r);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) m_plane[i] = '0;
    m_mode = MODE_NONE;
    m_coord = CRD_S;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first row runs on the reset state: mode none, coordinate s
    add_row(MODE_NONE, CRD_S, 0, 0, 0, 0,
            '{IMAX, IMIN, IMAX, IMIN, IMAX, IMIN, IMAX}, 1, 32'd0);
    add_row(MODE_NONE, CRD_Q, 0, 0, 0, 0, '0, 1, ONE_Q);
    add_row(3'd7, CRD_Q, 0, 0, 0, 0, '0, 1, ONE_Q);
    add_row(3'd6, CRD_T, 0, 0, 0, 0, '0, 1, 32'd0);
    add_row(MODE_OBJ, CRD_R, IMAX, IMAX, IMAX, IMAX,
            '{IMAX, IMAX, IMAX, IMAX, 0, 0, 0}, 1, IMAX);
    add_row(MODE_OBJ, CRD_R, IMAX, IMAX, IMAX, IMAX,
            '{IMIN, IMAX, IMAX, IMAX, 0, 0, 0}, 1, IMAX);
    add_row(MODE_OBJ, CRD_R, IMAX, IMAX, IMAX, IMAX,
            '{IMIN, IMIN, IMIN, IMIN, 0, 0, 0}, 1, IMIN);
    add_row(MODE_EYE, CRD_Q, ONE_Q, 0, 0, HALF_Q,
            '{32'h0003_0000, 5, 6, ONE_Q, 0, 0, 0}, 0, 0);
    add_row(MODE_SPHERE, CRD_R, 0, 0, 0, 0, '0, 1, 32'd0);
    add_row(MODE_SPHERE, CRD_Q, 0, 0, 0, 0, '0, 1, ONE_Q);
    add_row(MODE_SPHERE, CRD_S, 0, 0, 0, 0, '{0, 0, -ONE_Q, 0, 0, 0, 0}, 1, HALF_Q);
    add_row(MODE_SPHERE, CRD_S, 0, 0, 0, 0, '{ONE_Q, 0, 0, 0, 0, 0, ONE_Q}, 0, 0);
    add_row(MODE_SPHERE, CRD_S, 0, 0, 0, 0,
            '{IMAX, IMIN, IMAX, 0, IMAX, IMIN, IMIN}, 0, 0);
    add_row(MODE_SPHERE, CRD_T, 0, 0, 0, 0, '{0, IMIN, 0, 0, ONE_Q, 0, 0}, 0, 0);
    add_row(MODE_REFL, CRD_R, 0, 0, 0, 0, '{ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, ONE_Q}, 0, 0);
    add_row(MODE_REFL, CRD_R, 0, 0, 0, 0,
            '{IMAX, IMAX, IMAX, 0, IMAX, IMAX, IMAX}, 0, 0);
    add_row(MODE_REFL, CRD_Q, 0, 0, 0, 0, '0, 1, ONE_Q);
    add_row(MODE_NORMAL, CRD_T, 0, 0, 0, 0, '{0, 0, 0, 0, 1, IMIN, 3}, 1, IMIN);
    add_row(MODE_NORMAL, CRD_Q, 0, 0, 0, 0, '0, 1, ONE_Q);

    foreach (dir[i]) begin
      if (dir[i].mode != m_mode || dir[i].crd != m_coord ||
          dir[i].pa != m_plane[0] || dir[i].pb != m_plane[1] ||
          dir[i].pc != m_plane[2] || dir[i].pd != m_plane[3])
        set_cfg(dir[i].mode, dir[i].crd, dir[i].pa, dir[i].pb, dir[i].pc, dir[i].pd);
      send(dir[i].v, dir[i].known, dir[i].tc);
    end
    dir.delete();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      set_cfg(3'($urandom_range(7)), 2'($urandom_range(3)),
              ph == 4 ? IMIN : rfield($urandom_range(3)),
              ph == 4 ? IMIN : rfield($urandom_range(3)),
              ph == 8 ? IMAX : rfield($urandom_range(3)),
              ph == 8 ? IMAX : rfield($urandom_range(3)));
      for (int i = 0; i < 110; i++) begin
        if (i == 55) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (texcoord_q.size() != 0) @(posedge clk);
        end
        send(rvert(m_mode == MODE_SPHERE || m_mode == MODE_REFL), 0, 0);
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tcg_pkg.sv
sv/texture_coordinate_generator.sv
sv/tcg_checker.sv
sim/texture_coordinate_generator_tb.sv
